[hw/rtl/plb_pkg.sv]
// Package for the price level book: sizes, map geometry, queue and
// report-state types. No dependencies.
package plb_pkg;

   localparam int PriceLevels = 4096;
   localparam int TopLevels   = 8;
   localparam int MapWordBits = 64;
   localparam int MapWords    = PriceLevels / MapWordBits;
   localparam int IdxW        = $clog2(PriceLevels);
   localparam int BitW        = $clog2(MapWordBits);
   localparam int WordW       = $clog2(MapWords);
   localparam int RankW       = 3;
   localparam int CountW      = $clog2(TopLevels + 1);
   localparam int QtyW        = 32;
   localparam int QueueDepth  = 4;
   localparam int QueueAw     = $clog2(QueueDepth);

   // One classified command from the front part.
   typedef struct packed {
      logic            clear;
      logic            update;
      logic            is_bid;
      logic [IdxW-1:0] price_index;
      logic [QtyW-1:0] quantity;
      logic            report;
   } cmd_type;

   typedef enum logic [2:0] {
      EngIdle,
      EngClear,
      EngScanRead,
      EngScanPick,
      EngEmit,
      EngFill
   } eng_state_type;

   typedef struct packed {
      logic            is_bid;
      logic [RankW-1:0] rank;
      logic            present;
      logic [IdxW-1:0] price_index;
      logic [QtyW-1:0] quantity;
      logic            last_slot;
   } slot_type;

   function automatic logic [BitW-1:0] highest_set(input logic [MapWordBits-1:0] bits);
      logic [BitW-1:0] h;
      h = '0;
      for (int i = 0; i < MapWordBits; i++) begin
         if (bits[i]) begin
            h = BitW'(i);
         end
      end
      return h;
   endfunction

   function automatic logic [BitW-1:0] lowest_set(input logic [MapWordBits-1:0] bits);
      logic [BitW-1:0] l;
      l = '0;
      for (int i = MapWordBits - 1; i >= 0; i--) begin
         if (bits[i]) begin
            l = BitW'(i);
         end
      end
      return l;
   endfunction

endpackage

[hw/rtl/plb_if.sv]
// Valid/ready channel interfaces for the price level book.
// Depends on plb_pkg.
interface plb_req_if;
   logic                      valid;
   logic                      ready;
   logic                      has_level;
   logic                      is_bid;
   logic [plb_pkg::IdxW-1:0]  price_index;
   logic [plb_pkg::QtyW-1:0]  quantity;
   logic                      snapshot_start;
   logic                      end_of_event;
   modport source (output valid, has_level, is_bid, price_index, quantity,
                   snapshot_start, end_of_event, input ready);
   modport sink (input valid, has_level, is_bid, price_index, quantity,
                 snapshot_start, end_of_event, output ready);
endinterface

interface plb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      out_is_bid;
   logic [plb_pkg::RankW-1:0] rank;
   logic                      present;
   logic [plb_pkg::IdxW-1:0]  level_price_index;
   logic [plb_pkg::QtyW-1:0]  level_quantity;
   logic                      last_slot;
   modport source (output valid, out_is_bid, rank, present, level_price_index,
                   level_quantity, last_slot, input ready);
   modport sink (input valid, out_is_bid, rank, present, level_price_index,
                 level_quantity, last_slot, output ready);
endinterface

[hw/rtl/plb_front.sv]
// Front part: takes request transfers, classifies them into commands and
// queues them for the engine. Depends on plb_pkg and plb_if.
module plb_front (
   input  logic               clock,
   input  logic               reset,
   plb_req_if.sink            req,
   output logic               cmd_valid,
   output plb_pkg::cmd_type   cmd,
   input  logic               cmd_pop
);
   plb_pkg::cmd_type                 queue_ff [plb_pkg::QueueDepth];
   logic [plb_pkg::QueueAw-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [plb_pkg::QueueAw-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [plb_pkg::QueueAw:0]        fill_ff, fill_in;
   logic                             push;
   plb_pkg::cmd_type                 new_cmd;

   assign req.ready = (fill_ff != (plb_pkg::QueueAw+1)'(plb_pkg::QueueDepth));
   assign push      = req.valid && req.ready;

   always_comb begin
      new_cmd.clear       = req.snapshot_start;
      // out-of-range indexes can't occur at this book size; control-only items carry no update
      new_cmd.update      = req.has_level;
      new_cmd.is_bid      = req.is_bid;
      new_cmd.price_index = req.price_index;
      new_cmd.quantity    = req.quantity;
      new_cmd.report      = req.end_of_event;
   end

   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (plb_pkg::QueueAw+1)'(push)
                  - (plb_pkg::QueueAw+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end
endmodule

[hw/rtl/plb_engine.sv]
// Back part: applies level updates to the quantity stores and active maps,
// clears the book and runs the top-N scan. Depends on plb_pkg and plb_if.
module plb_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  plb_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   plb_rsp_if.source          rsp,
   output logic               busy
);
   localparam int IdxW  = plb_pkg::IdxW;
   localparam int BitW  = plb_pkg::BitW;
   localparam int WordW = plb_pkg::WordW;
   localparam int MWB   = plb_pkg::MapWordBits;

   // quantity stores: memories, undefined until written
   logic [plb_pkg::QtyW-1:0] bid_qty_mem [plb_pkg::PriceLevels];
   logic [plb_pkg::QtyW-1:0] ask_qty_mem [plb_pkg::PriceLevels];
   // active maps: one word per row with a valid bit each (row invalid reads zero)
   logic [MWB-1:0] bid_map_mem [plb_pkg::MapWords];
   logic [MWB-1:0] ask_map_mem [plb_pkg::MapWords];
   logic [plb_pkg::MapWords-1:0] bid_row_ok_ff, bid_row_ok_in;
   logic [plb_pkg::MapWords-1:0] ask_row_ok_ff, ask_row_ok_in;

   logic [IdxW-1:0] best_bid_ff, best_bid_in, best_ask_ff, best_ask_in;
   logic            bid_ok_ff, bid_ok_in, ask_ok_ff, ask_ok_in;

   plb_pkg::eng_state_type state_ff, state_in;
   logic            side_bid_ff, side_bid_in;          // side being scanned
   logic [WordW-1:0] word_ff, word_in;
   logic [MWB-1:0]  bits_ff, bits_in;
   logic            first_ff, first_in;
   logic            more_ff, more_in;                  // words left after bits_ff
   logic [plb_pkg::CountW-1:0] count_ff, count_in;
   logic [IdxW-1:0] pick_idx_ff, pick_idx_in;
   logic            upd_phase_ff, upd_phase_in;        // write phase of an update

   logic [MWB-1:0]  map_rd_ff;
   logic            map_rd_ok_ff;
   logic [plb_pkg::QtyW-1:0] qty_rd_ff;

   logic            out_valid_ff, out_valid_in;
   plb_pkg::slot_type out_ff, out_in;

   logic            map_rd_en, map_rd_bid;
   logic [WordW-1:0] map_rd_addr;
   logic            map_wr_en;
   logic [MWB-1:0]  map_wr_data;
   logic            qty_rd_en;
   logic [IdxW-1:0] qty_rd_addr;

   logic [WordW-1:0] upd_word;
   logic [BitW-1:0]  upd_bit;
   logic [MWB-1:0]   cur_map, first_mask, masked;
   logic [BitW-1:0]  pos;
   logic             out_free, last_word;

   assign upd_word  = cmd.price_index[IdxW-1:BitW];
   assign upd_bit   = cmd.price_index[BitW-1:0];
   assign out_free  = !out_valid_ff || rsp.ready;
   assign cur_map   = map_rd_ok_ff ? map_rd_ff : '0;
   assign last_word = side_bid_ff ? (word_ff == '0)
                                  : (word_ff == WordW'(plb_pkg::MapWords - 1));

   always_comb begin
      first_mask = '1;
      if (side_bid_ff) begin
         first_mask = ({{(MWB-1){1'b0}}, 1'b1} << best_bid_ff[BitW-1:0]);
         first_mask = (first_mask << 1) - 1'b1;
         if (best_bid_ff[BitW-1:0] == BitW'(MWB - 1)) first_mask = '1;
      end else begin
         first_mask = '1 << best_ask_ff[BitW-1:0];
      end
   end
   assign masked = first_ff ? (cur_map & first_mask) : cur_map;
   assign pos    = side_bid_ff ? plb_pkg::highest_set(bits_ff)
                               : plb_pkg::lowest_set(bits_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plb_pkg::EngIdle: begin
            if (cmd_valid && !upd_phase_ff) begin
               if (cmd.clear) state_in = plb_pkg::EngClear;
               else if (!cmd.update && cmd.report) state_in = plb_pkg::EngScanRead;
            end else if (upd_phase_ff && cmd.report) begin
               state_in = plb_pkg::EngScanRead;
            end
         end
         plb_pkg::EngClear: begin
            if (cmd.update) state_in = plb_pkg::EngIdle;
            else if (cmd.report) state_in = plb_pkg::EngScanRead;
            else state_in = plb_pkg::EngIdle;
         end
         plb_pkg::EngScanRead: state_in = plb_pkg::EngScanPick;
         plb_pkg::EngScanPick: begin
            if (count_ff == plb_pkg::CountW'(plb_pkg::TopLevels)) state_in = plb_pkg::EngFill;
            else if (bits_ff != '0) state_in = plb_pkg::EngEmit;
            else if (more_ff) state_in = plb_pkg::EngScanRead;
            else state_in = plb_pkg::EngFill;
         end
         plb_pkg::EngEmit: if (out_free) state_in = plb_pkg::EngScanPick;
         plb_pkg::EngFill: begin
            if (out_free && count_ff >= plb_pkg::CountW'(plb_pkg::TopLevels - 1)) begin
               state_in = side_bid_ff ? plb_pkg::EngScanRead : plb_pkg::EngIdle;
            end
         end
         default: state_in = plb_pkg::EngIdle;
      endcase
   end

   // datapath and outputs
   always_comb begin
      bid_row_ok_in = bid_row_ok_ff;
      ask_row_ok_in = ask_row_ok_ff;
      best_bid_in   = best_bid_ff;
      best_ask_in   = best_ask_ff;
      bid_ok_in     = bid_ok_ff;
      ask_ok_in     = ask_ok_ff;
      side_bid_in   = side_bid_ff;
      word_in       = word_ff;
      bits_in       = bits_ff;
      first_in      = first_ff;
      more_in       = more_ff;
      count_in      = count_ff;
      pick_idx_in   = pick_idx_ff;
      upd_phase_in  = 1'b0;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_in        = out_ff;
      cmd_pop       = 1'b0;
      map_rd_en     = 1'b0;
      map_rd_bid    = cmd.is_bid;
      map_rd_addr   = upd_word;
      map_wr_en     = 1'b0;
      map_wr_data   = '0;
      qty_rd_en     = 1'b0;
      qty_rd_addr   = cmd.price_index;

      unique case (state_ff)
         plb_pkg::EngIdle: begin
            if (upd_phase_ff) begin
               // write phase: modify and write the map word, move the best bound
               map_wr_en   = 1'b1;
               map_wr_data = cur_map;
               map_wr_data[upd_bit] = (cmd.quantity != '0);
               if (cmd.is_bid) bid_row_ok_in[upd_word] = 1'b1;
               else ask_row_ok_in[upd_word] = 1'b1;
               if (cmd.quantity != '0) begin
                  if (cmd.is_bid && (!bid_ok_ff || cmd.price_index > best_bid_ff)) begin
                     best_bid_in = cmd.price_index;
                     bid_ok_in   = 1'b1;
                  end
                  if (!cmd.is_bid && (!ask_ok_ff || cmd.price_index < best_ask_ff)) begin
                     best_ask_in = cmd.price_index;
                     ask_ok_in   = 1'b1;
                  end
               end
               side_bid_in = 1'b1;
               if (!cmd.report) cmd_pop = 1'b1;
            end else if (cmd_valid) begin
               if (cmd.clear) begin
                  // row valid bits drop at once
                  bid_row_ok_in = '0;
                  ask_row_ok_in = '0;
                  bid_ok_in     = 1'b0;
                  ask_ok_in     = 1'b0;
                  best_bid_in   = '0;
                  best_ask_in   = '0;
               end else if (cmd.update) begin
                  map_rd_en    = 1'b1;
                  upd_phase_in = 1'b1;
               end else begin
                  side_bid_in = 1'b1;
                  if (!cmd.report) cmd_pop = 1'b1;
               end
            end
            first_in = 1'b1;
            count_in = '0;
            word_in  = best_bid_ff[IdxW-1:BitW];
            if (upd_phase_ff && cmd.quantity != '0 && cmd.is_bid
                && (!bid_ok_ff || cmd.price_index > best_bid_ff)) begin
               word_in = upd_word;
            end
         end
         plb_pkg::EngClear: begin
            // snapshot done; run the update part as a fresh command
            if (cmd.update) begin
               // fall back to idle with clear consumed: re-enter via phase
               map_rd_en    = 1'b1;
               upd_phase_in = 1'b1;
            end else if (!cmd.report) begin
               cmd_pop = 1'b1;
            end
            side_bid_in = 1'b1;
            first_in    = 1'b1;
            count_in    = '0;
            word_in     = '0;
         end
         plb_pkg::EngScanRead: begin
            if (first_ff) begin
               word_in = side_bid_ff ? best_bid_ff[IdxW-1:BitW] : best_ask_ff[IdxW-1:BitW];
               if (!(side_bid_ff ? bid_ok_ff : ask_ok_ff)) begin
                  more_in = 1'b0;
               end
            end
            map_rd_en   = 1'b1;
            map_rd_bid  = side_bid_ff;
            map_rd_addr = first_ff ? (side_bid_ff ? best_bid_ff[IdxW-1:BitW]
                                                  : best_ask_ff[IdxW-1:BitW])
                                   : word_ff;
            bits_in = '0;
         end
         plb_pkg::EngScanPick: begin
            if (bits_ff == '0 && count_ff != plb_pkg::CountW'(plb_pkg::TopLevels)) begin
               if (more_ff) begin
                  word_in = side_bid_ff ? word_ff - 1'b1 : word_ff + 1'b1;
               end
            end else if (count_ff != plb_pkg::CountW'(plb_pkg::TopLevels)) begin
               pick_idx_in = {word_ff, pos};
               qty_rd_en   = 1'b1;
               qty_rd_addr = {word_ff, pos};
               map_rd_bid  = side_bid_ff;
               bits_in     = bits_ff;
               bits_in[pos] = 1'b0;
            end
         end
         plb_pkg::EngEmit: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.is_bid      = side_bid_ff;
               out_in.rank        = plb_pkg::RankW'(count_ff);
               out_in.present     = 1'b1;
               out_in.price_index = pick_idx_ff;
               out_in.quantity    = qty_rd_ff;
               out_in.last_slot   = !side_bid_ff
                  && count_ff == plb_pkg::CountW'(plb_pkg::TopLevels - 1);
               if (count_ff == '0) begin
                  if (side_bid_ff) begin best_bid_in = pick_idx_ff; bid_ok_in = 1'b1; end
                  else begin best_ask_in = pick_idx_ff; ask_ok_in = 1'b1; end
               end
               count_in = count_ff + 1'b1;
            end
         end
         plb_pkg::EngFill: begin
            if (count_ff == '0) begin
               if (side_bid_ff) begin best_bid_in = '0; bid_ok_in = 1'b0; end
               else begin best_ask_in = '0; ask_ok_in = 1'b0; end
            end
            if (count_ff == plb_pkg::CountW'(plb_pkg::TopLevels)) begin
               // side finished with all slots present
               if (side_bid_ff) begin
                  side_bid_in = 1'b0;
                  first_in    = 1'b1;
                  count_in    = '0;
               end else begin
                  cmd_pop = 1'b1;
               end
            end else if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.is_bid      = side_bid_ff;
               out_in.rank        = plb_pkg::RankW'(count_ff);
               out_in.present     = 1'b0;
               out_in.price_index = '0;
               out_in.quantity    = '0;
               out_in.last_slot   = !side_bid_ff
                  && count_ff == plb_pkg::CountW'(plb_pkg::TopLevels - 1);
               count_in = count_ff + 1'b1;
               if (count_ff == plb_pkg::CountW'(plb_pkg::TopLevels - 1)) begin
                  if (side_bid_ff) begin
                     side_bid_in = 1'b0;
                     first_in    = 1'b1;
                     count_in    = '0;
                  end else begin
                     cmd_pop = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase

      // first map word arrives in ScanPick: clear bits; seeding is done on scan_load_ff
      if (state_ff == plb_pkg::EngScanPick && bits_ff == '0 && first_ff) begin
         bits_in  = '0;
      end
   end

   // a fresh read issued in ScanRead lands in map_rd_ff in the cycle after it
   logic scan_load_ff;
   always_ff @(posedge clock) begin
      if (reset) scan_load_ff <= 1'b0;
      else scan_load_ff <= (state_ff == plb_pkg::EngScanRead);
   end

   logic [MWB-1:0] bits_sel;
   logic           more_sel, first_sel;
   logic           side_ok;
   always_comb begin
      side_ok   = side_bid_ff ? bid_ok_ff : ask_ok_ff;
      bits_sel  = bits_in;
      more_sel  = more_in;
      first_sel = first_in;
      if (scan_load_ff) begin
         bits_sel  = side_ok ? masked : '0;
         more_sel  = side_ok && !last_word;
         first_sel = 1'b0;
      end
   end

   // fill state handles the jump from a side with all slots to the next;
   // EngFill with count==TopLevels transitions through state_fix below
   plb_pkg::eng_state_type state_fix;
   always_comb begin
      state_fix = state_in;
      if (state_ff == plb_pkg::EngFill
          && count_ff == plb_pkg::CountW'(plb_pkg::TopLevels)) begin
         state_fix = side_bid_ff ? plb_pkg::EngScanRead : plb_pkg::EngIdle;
      end
      if (state_ff == plb_pkg::EngScanPick && scan_load_ff) begin
         if (side_ok && masked != '0) state_fix = plb_pkg::EngEmit;
         else if (side_ok && !last_word) state_fix = plb_pkg::EngScanRead;
         else state_fix = plb_pkg::EngFill;
      end
   end

   logic [IdxW-1:0] load_pick;
   always_comb begin
      load_pick = pick_idx_in;
      if (state_ff == plb_pkg::EngScanPick && scan_load_ff) begin
         load_pick = {word_ff, side_bid_ff ? plb_pkg::highest_set(masked)
                                           : plb_pkg::lowest_set(masked)};
      end
   end

   logic [MWB-1:0] load_bits;
   always_comb begin
      load_bits = bits_sel;
      if (state_ff == plb_pkg::EngScanPick && scan_load_ff && masked != '0) begin
         load_bits = masked;
         load_bits[load_pick[BitW-1:0]] = 1'b0;
      end
   end

   logic            q_rd_en;
   logic [IdxW-1:0] q_rd_addr;
   always_comb begin
      q_rd_en   = qty_rd_en;
      q_rd_addr = qty_rd_addr;
      if (state_ff == plb_pkg::EngScanPick && scan_load_ff) begin
         q_rd_en   = side_ok && masked != '0;
         q_rd_addr = load_pick;
      end
   end

   // on a fresh word the previous word's more flag is stale: step only when
   // the new word is empty and more words remain
   logic [WordW-1:0] word_sel;
   always_comb begin
      word_sel = word_in;
      if (state_ff == plb_pkg::EngScanPick && scan_load_ff) begin
         word_sel = word_ff;
         if (side_ok && masked == '0 && !last_word) begin
            word_sel = side_bid_ff ? word_ff - 1'b1 : word_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= plb_pkg::EngIdle;
         bid_row_ok_ff <= '0;
         ask_row_ok_ff <= '0;
         best_bid_ff   <= '0;
         best_ask_ff   <= '0;
         bid_ok_ff     <= 1'b0;
         ask_ok_ff     <= 1'b0;
         upd_phase_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         side_bid_ff   <= 1'b1;
         first_ff      <= 1'b1;
         more_ff       <= 1'b0;
         count_ff      <= '0;
         word_ff       <= '0;
      end else begin
         state_ff      <= state_fix;
         bid_row_ok_ff <= bid_row_ok_in;
         ask_row_ok_ff <= ask_row_ok_in;
         best_bid_ff   <= best_bid_in;
         best_ask_ff   <= best_ask_in;
         bid_ok_ff     <= bid_ok_in;
         ask_ok_ff     <= ask_ok_in;
         upd_phase_ff  <= upd_phase_in;
         out_valid_ff  <= out_valid_in;
         side_bid_ff   <= side_bid_in;
         first_ff      <= first_sel;
         more_ff       <= more_sel;
         count_ff      <= count_in;
         word_ff       <= word_sel;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff     <= load_bits;
      pick_idx_ff <= load_pick;
      out_ff      <= out_in;
   end

   // map words: one read port, one write port
   always_ff @(posedge clock) begin
      if (map_rd_en) begin
         map_rd_ff    <= map_rd_bid ? bid_map_mem[map_rd_addr] : ask_map_mem[map_rd_addr];
         map_rd_ok_ff <= map_rd_bid ? bid_row_ok_ff[map_rd_addr]
                                    : ask_row_ok_ff[map_rd_addr];
      end
      if (map_wr_en) begin
         if (cmd.is_bid) bid_map_mem[upd_word] <= map_wr_data;
         else ask_map_mem[upd_word] <= map_wr_data;
      end
   end

   // quantity stores
   always_ff @(posedge clock) begin
      if (q_rd_en) begin
         qty_rd_ff <= side_bid_ff ? bid_qty_mem[q_rd_addr] : ask_qty_mem[q_rd_addr];
      end
      if (upd_phase_ff && state_ff == plb_pkg::EngIdle) begin
         if (cmd.is_bid) bid_qty_mem[cmd.price_index] <= cmd.quantity;
         else ask_qty_mem[cmd.price_index] <= cmd.quantity;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.out_is_bid        = out_ff.is_bid;
   assign rsp.rank              = out_ff.rank;
   assign rsp.present           = out_ff.present;
   assign rsp.level_price_index = out_ff.price_index;
   assign rsp.level_quantity    = out_ff.quantity;
   assign rsp.last_slot         = out_ff.last_slot;
   assign busy = (state_ff != plb_pkg::EngIdle) || upd_phase_ff;
endmodule

[hw/rtl/price_level_book_top_n.sv]
// Channel   Dir  Handshake          Payload
// req       in   req_valid/ready    has_level is_bid price_index quantity snapshot/eoe
// rsp       out  rsp_valid/ready    out_is_bid rank present price qty last_slot
// A level update in the engine reads the map word, then writes it back.
// A report reads each scanned map word through the single map-word read port,
// then emits present slots after a quantity read and absent slots directly;
// reset is synchronous. A snapshot passes through a Clear state and drops all
// row valid bits at once. A 4-deep command queue lets the request side keep
// transferring while the engine stalls on rsp; each slot waits in Emit/Fill
// until rsp has room. Depends on plb_pkg, plb_if, plb_front, plb_engine.
module price_level_book_top_n (
   input  logic     clock,
   input  logic     reset,
   plb_req_if.sink  req,
   plb_rsp_if.source rsp
);
   logic             cmd_valid, cmd_pop, busy;
   plb_pkg::cmd_type cmd;

   plb_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
   );

   plb_engine u_engine (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_pop(cmd_pop), .rsp(rsp), .busy(busy)
   );

`ifndef SYNTH
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty queue");
   a_busy_has_cmd: assert property (@(posedge clock) disable iff (reset)
      busy |-> cmd_valid) else $error("engine busy without a command");
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.present) |-> (rsp.level_quantity == '0
      && rsp.level_price_index == '0)) else $error("absent slot carries data");
   a_last_is_ask: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_slot) |-> !rsp.out_is_bid)
      else $error("last slot on bid side");
`endif
endmodule

[dv/plb_tb_pkg.sv]
// Testbench package for the price level book: stimulus item type.
// Depends on plb_pkg.
package plb_tb_pkg;

   typedef struct packed {
      logic                     has_level;
      logic                     is_bid;
      logic [plb_pkg::IdxW-1:0] price_index;
      logic [plb_pkg::QtyW-1:0] quantity;
      logic                     snapshot_start;
      logic                     end_of_event;
   } level_item_type;

endpackage

[dv/tb.sv]
// Testbench top for price_level_book_top_n: directed and random level
// updates, a bitmap book predictor, and an in-order check of report slots.
// Depends on plb_pkg, plb_if, plb_tb_pkg and the block's RTL.
module tb;

   localparam int CycleLimit = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plb_req_if req ();
   plb_rsp_if rsp ();

   price_level_book_top_n u_top (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always #5 clock = ~clock;

   // Book shadow
   logic [plb_pkg::QtyW-1:0]        bid_qty [plb_pkg::PriceLevels];
   logic [plb_pkg::QtyW-1:0]        ask_qty [plb_pkg::PriceLevels];
   logic [plb_pkg::PriceLevels-1:0] bid_map;
   logic [plb_pkg::PriceLevels-1:0] ask_map;
   int unsigned            best_bid;
   logic                   best_bid_ok;
   int unsigned            best_ask;
   logic                   best_ask_ok;

   plb_tb_pkg::level_item_type pending_items[$];
   plb_pkg::slot_type          expected_slots[$];

   int  errors = 0;
   int  cycles = 0;
   int  slots_seen = 0;
   int  reports = 0;
   bit  stim_done = 1'b0;
   bit  calm = 1'b0;
   int  used_bid[$];
   int  used_ask[$];

   task automatic clear_book();
      bid_map = '0;
      ask_map = '0;
      best_bid = 0;
      best_bid_ok = 1'b0;
      best_ask = 0;
      best_ask_ok = 1'b0;
   endtask

   function automatic plb_pkg::slot_type make_slot(logic bid, int rank, logic pres, int idx,
                                                   logic [plb_pkg::QtyW-1:0] q, logic last);
      plb_pkg::slot_type s;
      s.is_bid      = bid;
      s.rank        = plb_pkg::RankW'(rank);
      s.present     = pres;
      s.price_index = pres ? plb_pkg::IdxW'(idx) : '0;
      s.quantity    = pres ? q : '0;
      s.last_slot   = last;
      return s;
   endfunction

   // Scan from the stored bounds, same as the block: a stale bound still sits
   // above (bid) or below (ask) every active level.
   task automatic predict_report();
      int cnt;
      int first;
      cnt = 0;
      first = 0;
      if (best_bid_ok) begin
         for (int i = int'(best_bid); i >= 0 && cnt < plb_pkg::TopLevels; i--) begin
            if (bid_map[i]) begin
               if (cnt == 0) first = i;
               expected_slots.push_back(make_slot(1'b1, cnt, 1'b1, i, bid_qty[i], 1'b0));
               cnt++;
            end
         end
      end
      best_bid_ok = cnt > 0;
      best_bid = cnt > 0 ? first : 0;
      for (; cnt < plb_pkg::TopLevels; cnt++)
         expected_slots.push_back(make_slot(1'b1, cnt, 1'b0, 0, '0, 1'b0));
      cnt = 0;
      first = 0;
      if (best_ask_ok) begin
         for (int i = int'(best_ask); i < plb_pkg::PriceLevels && cnt < plb_pkg::TopLevels;
              i++) begin
            if (ask_map[i]) begin
               if (cnt == 0) first = i;
               expected_slots.push_back(make_slot(1'b0, cnt, 1'b1, i, ask_qty[i],
                                                  cnt == plb_pkg::TopLevels - 1));
               cnt++;
            end
         end
      end
      best_ask_ok = cnt > 0;
      best_ask = cnt > 0 ? first : 0;
      for (; cnt < plb_pkg::TopLevels; cnt++)
         expected_slots.push_back(make_slot(1'b0, cnt, 1'b0, 0, '0,
                                            cnt == plb_pkg::TopLevels - 1));
      reports++;
   endtask

   task automatic predict_item(plb_tb_pkg::level_item_type it);
      int idx;
      idx = it.price_index;
      if (it.snapshot_start) clear_book();
      if (it.has_level) begin
         if (it.is_bid) begin
            bid_qty[idx] = it.quantity;
            bid_map[idx] = it.quantity != 0;
            if (it.quantity != 0 && (!best_bid_ok || idx > best_bid)) begin
               best_bid = idx;
               best_bid_ok = 1'b1;
            end
         end else begin
            ask_qty[idx] = it.quantity;
            ask_map[idx] = it.quantity != 0;
            if (it.quantity != 0 && (!best_ask_ok || idx < best_ask)) begin
               best_ask = idx;
               best_ask_ok = 1'b1;
            end
         end
      end
      if (it.end_of_event) predict_report();
   endtask

   function automatic plb_tb_pkg::level_item_type mk(logic hl, logic bid, int idx,
                                                     logic [31:0] q, logic snap, logic eoe);
      plb_tb_pkg::level_item_type it;
      it.has_level = hl;
      it.is_bid = bid;
      it.price_index = plb_pkg::IdxW'(idx);
      it.quantity = q;
      it.snapshot_start = snap;
      it.end_of_event = eoe;
      return it;
   endfunction

   function automatic int rand_idx(logic bid);
      int r;
      r = $urandom_range(0, 9);
      // Half the time reuse a prior level so that removals hit active ones
      if (bid && used_bid.size() > 0 && r < 5) return used_bid[$urandom_range(0, used_bid.size()-1)];
      if (!bid && used_ask.size() > 0 && r < 5) return used_ask[$urandom_range(0, used_ask.size()-1)];
      if (r == 5) return $urandom_range(0, 1) ? 0 : plb_pkg::PriceLevels - 1;
      if (r < 8) return $urandom_range(1900, 2200);
      return $urandom_range(0, plb_pkg::PriceLevels - 1);
   endfunction

   function automatic logic [31:0] rand_qty();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 32'd0;
      if (r == 3) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) void'(pending_items.pop_front());
         if (req.valid && !req.ready) begin
            // hold current item
         end else if (pending_items.size() > 0
                      && (calm || $urandom_range(0, 99) >= 24)) begin
            req.valid          <= 1'b1;
            req.has_level      <= pending_items[0].has_level;
            req.is_bid         <= pending_items[0].is_bid;
            req.price_index    <= pending_items[0].price_index;
            req.quantity       <= pending_items[0].quantity;
            req.snapshot_start <= pending_items[0].snapshot_start;
            req.end_of_event   <= pending_items[0].end_of_event;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor / checker; prediction happens on accepted request transfers
   always @(posedge clock) begin
      plb_pkg::slot_type exp_s;
      if (!reset) begin
         rsp.ready <= calm || $urandom_range(0, 99) >= 24;
         if (req.valid && req.ready)
            predict_item(mk(req.has_level, req.is_bid, req.price_index, req.quantity,
                            req.snapshot_start, req.end_of_event));
         if (rsp.valid && rsp.ready) begin
            slots_seen++;
            if (expected_slots.size() == 0) begin
               $error("unexpected slot transfer");
               errors++;
            end else begin
               exp_s = expected_slots.pop_front();
               if (rsp.out_is_bid !== exp_s.is_bid) begin
                  $error("out_is_bid exp %0d got %0d", exp_s.is_bid, rsp.out_is_bid); errors++;
               end
               if (rsp.rank !== exp_s.rank) begin
                  $error("rank exp %0d got %0d", exp_s.rank, rsp.rank); errors++;
               end
               if (rsp.present !== exp_s.present) begin
                  $error("present exp %0d got %0d", exp_s.present, rsp.present); errors++;
               end
               if (rsp.level_price_index !== exp_s.price_index) begin
                  $error("level_price_index exp %0d got %0d", exp_s.price_index,
                         rsp.level_price_index); errors++;
               end
               if (rsp.level_quantity !== exp_s.quantity) begin
                  $error("level_quantity exp %0h got %0h", exp_s.quantity,
                         rsp.level_quantity); errors++;
               end
               if (rsp.last_slot !== exp_s.last_slot) begin
                  $error("last_slot exp %0d got %0d", exp_s.last_slot, rsp.last_slot); errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int n;
      logic bid;
      int idx;
      req.valid = 1'b0;
      req.has_level = 1'b0;
      req.is_bid = 1'b0;
      req.price_index = '0;
      req.quantity = '0;
      req.snapshot_start = 1'b0;
      req.end_of_event = 1'b0;
      rsp.ready = 1'b0;
      clear_book();
      // Directed: empty report, extremes, stale best removal, ignored fields,
      // snapshot with update, control-only items.
      pending_items.push_back(mk(0, 0, 0, 0, 0, 1));
      pending_items.push_back(mk(1, 1, 0, 32'hFFFF_FFFF, 0, 0));
      pending_items.push_back(mk(1, 1, 4095, 32'h1, 0, 0));
      pending_items.push_back(mk(1, 0, 0, 32'h5, 0, 0));
      pending_items.push_back(mk(1, 0, 4095, 32'hFFFF_FFFF, 0, 1));
      pending_items.push_back(mk(1, 1, 4095, 0, 0, 0));
      pending_items.push_back(mk(1, 0, 0, 0, 0, 1));
      pending_items.push_back(mk(0, 1, 4095, 32'hFFFF_FFFF, 0, 1));
      for (int i = 0; i < 10; i++)
         pending_items.push_back(mk(1, i[0], 60 + i * 3, 100 + i, 0, 0));
      pending_items.push_back(mk(1, 1, 63, 7, 0, 1));
      pending_items.push_back(mk(1, 0, 64, 9, 1, 1));
      pending_items.push_back(mk(0, 0, 0, 0, 1, 1));
      pending_items.push_back(mk(1, 1, 2048, 0, 0, 1));
      wait (!reset);
      // Random events: snapshot sometimes, several updates, then report.
      n = 0;
      while (n < 340) begin
         int len;
         len = $urandom_range(1, 12);
         if ($urandom_range(0, 9) == 0) begin
            used_bid.delete();
            used_ask.delete();
         end
         for (int j = 0; j < len; j++) begin
            bid = $urandom_range(0, 1);
            idx = rand_idx(bid);
            if (bid) used_bid.push_back(idx); else used_ask.push_back(idx);
            pending_items.push_back(mk($urandom_range(0, 19) != 0, bid, idx, rand_qty(),
                                       j == 0 && $urandom_range(0, 9) == 0,
                                       j == len - 1 || $urandom_range(0, 19) == 0));
            n++;
         end
         if (n > 120 && n < 200) calm = 1'b1; else calm = 1'b0;
         while (pending_items.size() > 20) @(posedge clock);
      end
      calm = 1'b0;
      while (pending_items.size() > 0) @(posedge clock);
      stim_done = 1'b1;
      while (expected_slots.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Ran %0d reports, %0d slots checked, with idling on both channels",
               reports, slots_seen);
      if (errors == 0 && expected_slots.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

[files.f]
hw/rtl/plb_pkg.sv
hw/rtl/plb_if.sv
hw/rtl/plb_front.sv
hw/rtl/plb_engine.sv
hw/rtl/price_level_book_top_n.sv
dv/plb_tb_pkg.sv
dv/tb.sv
